// ===== sv/roi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_pkg
// Shared types, codes and sizes of the retire window monitor.
// ----------------------------------------------------------------------------
package roi_pkg;

   localparam int SEGMENTS_DEF       = 8;
   localparam int SCHEDULE_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam logic [63:0] ALL_ONES  = '1;

   typedef enum logic [1:0] {
      REQ_RETIRE   = 2'd0,
      REQ_ACK      = 2'd1,
      REQ_LOAD_SEG = 2'd2,
      REQ_LOAD_SCH = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_BEGIN  = 2'd1,
      EV_WINDOW = 2'd2,
      EV_END    = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_NO_EVENT = 2'd1,
      ERR_OVERFLOW = 2'd2
   } error_type;

   typedef enum logic [2:0] {
      MODE_WAIT    = 3'b001,
      MODE_COLLECT = 3'b010,
      MODE_ENDED   = 3'b100
   } mode_type;

   typedef enum logic [3:0] {
      CSR_START_PC     = 4'd0,
      CSR_END_PC       = 4'd1,
      CSR_IMAGE_BASE   = 4'd2,
      CSR_FIXED_WINDOW = 4'd3,
      CSR_SEG_COUNT    = 4'd4,
      CSR_SCHED_LEN    = 4'd5,
      CSR_TRACE_EN     = 4'd6,
      CSR_CHUNK_REC    = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] pc;
      logic        origin_user;
      logic [15:0] address_space;
      logic [3:0]  table_index;
      logic [63:0] table_value;
   } req_item_type;

   // A request after classification by the front end.
   typedef struct packed {
      req_item_type req;
      logic         seg_hit;
   } work_item_type;

   typedef struct packed {
      logic        trace_valid;
      logic [63:0] trace_value;
      logic        chunk_last;
      logic        flush_close;
      logic [1:0]  event_kind;
      logic        stop_request;
      logic [63:0] retired_count;
      logic [63:0] workload_count;
      logic [1:0]  error_code;
   } rsp_item_type;

   typedef struct packed {
      logic [63:0] start_pc;
      logic [63:0] end_pc;
      logic [63:0] image_base;
      logic [63:0] fixed_window;
      logic [3:0]  segment_count;
      logic [4:0]  schedule_length;
      logic        trace_enable;
      logic [16:0] chunk_records;
   } cfg_type;

   typedef struct packed {
      logic [1:0] pending;
      logic [1:0] kind;
      logic       stop;
   } raise_type;

   // Event arbitration: an end replaces a pending window, others are dropped.
   function automatic raise_type raise_event(logic [1:0] pending, logic [1:0] ev);
      raise_type r;
      r.pending = pending;
      r.kind    = EV_NONE;
      r.stop    = 1'b0;
      if (pending == EV_END) begin
         r.kind = EV_NONE;
      end else if (pending == EV_WINDOW && ev == EV_END) begin
         r.pending = EV_END;
         r.kind    = EV_END;
      end else if (pending == EV_NONE) begin
         r.pending = ev;
         r.kind    = ev;
         r.stop    = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== sv/roi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_if
// Valid/ready channels of the retire window monitor.
// ----------------------------------------------------------------------------
interface roi_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] pc;
   logic        origin_user;
   logic [15:0] address_space;
   logic [3:0]  table_index;
   logic [63:0] table_value;
   modport source (output valid, req_type, pc, origin_user, address_space,
                   table_index, table_value, input ready);
   modport sink (input valid, req_type, pc, origin_user, address_space,
                 table_index, table_value, output ready);
endinterface

interface roi_rsp_if;
   logic        valid;
   logic        ready;
   logic        trace_valid;
   logic [63:0] trace_value;
   logic        chunk_last;
   logic        flush_close;
   logic [1:0]  event_kind;
   logic        stop_request;
   logic [63:0] retired_count;
   logic [63:0] workload_count;
   logic [1:0]  error_code;
   modport source (output valid, trace_valid, trace_value, chunk_last, flush_close,
                   event_kind, stop_request, retired_count, workload_count,
                   error_code, input ready);
   modport sink (input valid, trace_valid, trace_value, chunk_last, flush_close,
                 event_kind, stop_request, retired_count, workload_count,
                 error_code, output ready);
endinterface

interface roi_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/roi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_front
// Holds the segment table and tags each request with its segment match.
// ----------------------------------------------------------------------------
module roi_front
   import roi_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEF
) (
   input  logic          clock,
   input  logic          in_valid,
   input  req_item_type  in_item,
   input  logic          accept,
   input  logic [3:0]    segment_count,
   output work_item_type out_item
);

   localparam int ENTRIES = 2 * SEGMENTS;

   logic [63:0] bounds_ff [ENTRIES];
   logic [SEGMENTS-1:0] hit;

   for (genvar e = 0; e < ENTRIES; e++) begin : g_entry
      always_ff @(posedge clock) begin
         if (accept && in_valid && in_item.req_type == REQ_LOAD_SEG &&
             int'(in_item.table_index) == e) begin
            bounds_ff[e] <= in_item.table_value;
         end
      end
   end

   for (genvar s = 0; s < SEGMENTS; s++) begin : g_seg
      assign hit[s] = (int'(segment_count) > s) &&
                      (in_item.pc >= bounds_ff[2*s]) &&
                      (in_item.pc < bounds_ff[2*s+1]);
   end

   assign out_item.req     = in_item;
   assign out_item.seg_hit = |hit;

endmodule

// ===== sv/roi_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module roi_queue
   import roi_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  work_item_type push_item,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output work_item_type head_item
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   work_item_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
      return (int'(p) == DEPTH - 1) ? '0 : PW'(p + 1'b1);
   endfunction

   always_comb begin
      wr_in    = push ? bump(wr_ff) : wr_ff;
      rd_in    = pop ? bump(rd_ff) : rd_ff;
      count_in = CW'(count_ff + CW'(push) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   assign full      = (int'(count_ff) == DEPTH);
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ff];

endmodule

// ===== sv/roi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_back
// Executes classified requests: mode, events, counters, windows and trace.
// ----------------------------------------------------------------------------
module roi_back
   import roi_pkg::*;
#(
   parameter int SCHEDULE_DEPTH = SCHEDULE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   input  work_item_type in_item,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output rsp_item_type  out_item
);

   localparam int WW = $clog2(SCHEDULE_DEPTH + 1);

   mode_type     mode_ff, mode_in;
   logic [1:0]   pending_ff, pending_in;
   logic [15:0]  owner_ff, owner_in;
   logic [63:0]  retired_ff, retired_in;
   logic [63:0]  workload_ff, workload_in;
   logic [63:0]  boundary_ff, boundary_in;
   logic [WW-1:0] widx_ff, widx_in;
   logic [16:0]  fill_ff, fill_in;
   logic         closed_ff, closed_in;
   logic         valid_ff;
   rsp_item_type rsp_ff, rsp_in;
   logic [63:0]  sched_ff [SCHEDULE_DEPTH];

   req_item_type  rq;
   logic [WW-1:0] len;
   logic [WW-1:0] rd_addr;
   logic [63:0]   sched_rd;
   logic [63:0]   add;
   logic [64:0]   sum;
   logic [16:0]   lim;
   logic          owner;
   raise_type     rv;

   assign rq  = in_item.req;
   assign pop = in_valid && (!valid_ff || out_ready);
   assign len = (int'(cfg.schedule_length) > SCHEDULE_DEPTH) ?
                WW'(SCHEDULE_DEPTH) : WW'(cfg.schedule_length);
   assign rd_addr = (rq.req_type == REQ_ACK) ? '0 : WW'(widx_ff + 1'b1);

   always_comb begin
      sched_rd = '0;
      for (int e = 0; e < SCHEDULE_DEPTH; e++) begin
         if (int'(rd_addr) == e) begin
            sched_rd = sched_ff[e];
         end
      end
   end

   for (genvar e = 0; e < SCHEDULE_DEPTH; e++) begin : g_sched
      always_ff @(posedge clock) begin
         if (pop && rq.req_type == REQ_LOAD_SCH && int'(rq.table_index) == e) begin
            sched_ff[e] <= rq.table_value;
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      pending_in  = pending_ff;
      owner_in    = owner_ff;
      retired_in  = retired_ff;
      workload_in = workload_ff;
      boundary_in = boundary_ff;
      widx_in     = widx_ff;
      fill_in     = fill_ff;
      closed_in   = closed_ff;
      rsp_in      = '0;
      owner       = rq.origin_user && (rq.address_space == owner_ff);
      lim         = (cfg.chunk_records == '0) ? 17'd1 : cfg.chunk_records;
      add         = '0;
      sum         = '0;
      rv          = '0;
      unique case (rq.req_type)
         REQ_RETIRE: begin
            unique case (mode_ff)
               MODE_WAIT: begin
                  if (rq.pc == cfg.start_pc && rq.origin_user &&
                      rq.address_space != '0 && pending_ff == EV_NONE) begin
                     owner_in = rq.address_space;
                     rv = raise_event(pending_ff, EV_BEGIN);
                     pending_in = rv.pending;
                     rsp_in.event_kind   = rv.kind;
                     rsp_in.stop_request = rv.stop;
                  end
               end
               MODE_COLLECT: begin
                  if (owner && rq.pc == cfg.end_pc) begin
                     if (cfg.trace_enable && !closed_ff) begin
                        rsp_in.flush_close = 1'b1;
                        closed_in = 1'b1;
                        fill_in   = '0;
                     end
                     rv = raise_event(pending_ff, EV_END);
                     pending_in = rv.pending;
                     rsp_in.event_kind   = rv.kind;
                     rsp_in.stop_request = rv.stop;
                  end else begin
                     retired_in = retired_ff + 64'd1;
                     if (owner) begin
                        workload_in = workload_ff + 64'd1;
                        if (cfg.trace_enable && !closed_ff) begin
                           rsp_in.trace_valid = 1'b1;
                           rsp_in.trace_value = in_item.seg_hit ?
                                                rq.pc - cfg.image_base : ALL_ONES;
                           fill_in = 17'(fill_ff + 1'b1);
                           if (fill_in >= lim) begin
                              rsp_in.chunk_last = 1'b1;
                              fill_in = '0;
                           end
                        end
                        if (boundary_ff != '0 && workload_in >= boundary_ff) begin
                           if (len != '0) begin
                              widx_in = WW'(widx_ff + 1'b1);
                              add     = sched_rd;
                           end else begin
                              add = cfg.fixed_window;
                           end
                           sum = {1'b0, boundary_ff} + {1'b0, add};
                           if (len != '0 && widx_in >= len) begin
                              boundary_in = '0;
                           end else if (sum[64]) begin
                              rsp_in.error_code = ERR_OVERFLOW;
                              boundary_in = '0;
                           end else begin
                              boundary_in = sum[63:0];
                           end
                           rv = raise_event(pending_ff, EV_WINDOW);
                           pending_in = rv.pending;
                           rsp_in.event_kind   = rv.kind;
                           rsp_in.stop_request = rv.stop;
                        end
                     end
                  end
               end
               MODE_ENDED: begin
               end
               default: begin
               end
            endcase
         end
         REQ_ACK: begin
            if (pending_ff == EV_NONE) begin
               rsp_in.error_code = ERR_NO_EVENT;
            end else begin
               if (pending_ff == EV_BEGIN) begin
                  mode_in     = MODE_COLLECT;
                  widx_in     = '0;
                  boundary_in = (len != '0) ? sched_rd : cfg.fixed_window;
               end else if (pending_ff == EV_END) begin
                  mode_in = MODE_ENDED;
               end
               pending_in = EV_NONE;
            end
         end
         REQ_LOAD_SEG, REQ_LOAD_SCH: begin
         end
         default: begin
         end
      endcase
      rsp_in.retired_count  = retired_in;
      rsp_in.workload_count = workload_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_WAIT;
         pending_ff  <= EV_NONE;
         owner_ff    <= '0;
         retired_ff  <= '0;
         workload_ff <= '0;
         boundary_ff <= '0;
         widx_ff     <= '0;
         fill_ff     <= '0;
         closed_ff   <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (pop) begin
            mode_ff     <= mode_in;
            pending_ff  <= pending_in;
            owner_ff    <= owner_in;
            retired_ff  <= retired_in;
            workload_ff <= workload_in;
            boundary_ff <= boundary_in;
            widx_ff     <= widx_in;
            fill_ff     <= fill_in;
            closed_ff   <= closed_in;
            valid_ff    <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = rsp_ff;

`ifndef ASSERT_OFF
   a_ended_no_count: assert property (@(posedge clock) disable iff (reset)
      (pop && mode_ff == MODE_ENDED) |=> $stable(retired_ff))
      else $error("retire counted after end");
   a_workload_le_retired: assert property (@(posedge clock) disable iff (reset)
      workload_ff <= retired_ff)
      else $error("workload count above retired count");
   a_closed_fill: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> fill_ff == '0)
      else $error("chunk fill moved after trace close");
   a_stop_has_event: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_ff.stop_request) |-> rsp_ff.event_kind != EV_NONE)
      else $error("stop request without event");
`endif

endmodule

// ===== sv/roi_retire_window_monitor.sv =====
`timescale 1ns / 1ps
// An accepted request is written into the queue; the back end executes it at
// the queue head and registers its response in its output register.
// Throughput: one request per cycle; the back end retires one queued request
// each cycle in which its output register is empty or being taken.
// Reset: synchronous, active high; control state and configuration return to
// their defaults at once, the segment and schedule tables hold no reset value.
// ----------------------------------------------------------------------------
// roi_retire_window_monitor
// Region-of-interest monitor of a retire stream with window and trace output.
// ----------------------------------------------------------------------------
module roi_retire_window_monitor
   import roi_pkg::*;
#(
   parameter int SEGMENTS       = SEGMENTS_DEF,
   parameter int SCHEDULE_DEPTH = SCHEDULE_DEPTH_DEF
) (
   input logic     clock,
   input logic     reset,
   roi_req_if.sink   req_chan,
   roi_rsp_if.source rsp_chan,
   roi_csr_if.sink   csr_chan
);

   // Register values after reset: everything clear except a chunk of 4096.
   localparam cfg_type CFG_RESET = {64'd0, 64'd0, 64'd0, 64'd0, 4'd0, 5'd0, 1'b0,
                                    17'd4096};

   // Configuration registers. The user must write them only while the block is
   // idle, not enforced by the block; both ends read them without any staging.
   cfg_type cfg_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_START_PC:     cfg_ff.start_pc        <= csr_chan.data;
            CSR_END_PC:       cfg_ff.end_pc          <= csr_chan.data;
            CSR_IMAGE_BASE:   cfg_ff.image_base      <= csr_chan.data;
            CSR_FIXED_WINDOW: cfg_ff.fixed_window    <= csr_chan.data;
            CSR_SEG_COUNT:    cfg_ff.segment_count   <= csr_chan.data[3:0];
            CSR_SCHED_LEN:    cfg_ff.schedule_length <= csr_chan.data[4:0];
            CSR_TRACE_EN:     cfg_ff.trace_enable    <= csr_chan.data[0];
            CSR_CHUNK_REC:    cfg_ff.chunk_records   <= csr_chan.data[16:0];
            default: begin
            end
         endcase
      end
   end

   // The front end classifies each request against the segment table as it
   // is accepted and places it in the queue.
   req_item_type  req_item;
   work_item_type front_item, head_item;
   logic          q_full, q_not_empty, q_pop, accept;
   rsp_item_type  rsp_item;

   assign req_item.req_type      = req_chan.req_type;
   assign req_item.pc            = req_chan.pc;
   assign req_item.origin_user   = req_chan.origin_user;
   assign req_item.address_space = req_chan.address_space;
   assign req_item.table_index   = req_chan.table_index;
   assign req_item.table_value   = req_chan.table_value;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   roi_front #(.SEGMENTS(SEGMENTS)) u_front (
      .clock         (clock),
      .in_valid      (req_chan.valid),
      .in_item       (req_item),
      .accept        (accept),
      .segment_count (cfg_ff.segment_count),
      .out_item      (front_item)
   );

   roi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   // The back end owns all sequencing state and the response register.
   roi_back #(.SCHEDULE_DEPTH(SCHEDULE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (q_not_empty),
      .in_item   (head_item),
      .pop       (q_pop),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (rsp_item)
   );

   assign rsp_chan.trace_valid    = rsp_item.trace_valid;
   assign rsp_chan.trace_value    = rsp_item.trace_value;
   assign rsp_chan.chunk_last     = rsp_item.chunk_last;
   assign rsp_chan.flush_close    = rsp_item.flush_close;
   assign rsp_chan.event_kind     = rsp_item.event_kind;
   assign rsp_chan.stop_request   = rsp_item.stop_request;
   assign rsp_chan.retired_count  = rsp_item.retired_count;
   assign rsp_chan.workload_count = rsp_item.workload_count;
   assign rsp_chan.error_code     = rsp_item.error_code;

endmodule
